// ===== rtl/prq_pkg.sv =====
// shared constants and control structs for the priority run queue
`timescale 1ns / 1ps

package prq_pkg;

  localparam int NUM_PRIO_DEF  = 128;
  localparam int NUM_TASKS_DEF = 64;

  // fixed field widths of the stream words
  localparam int PRIO_W    = 7;
  localparam int TASK_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  // level bitmap is searched in groups of this many levels
  localparam int GROUP_W     = 16;
  localparam int GROUP_BIT_W = 4;

  // operation codes carried in s_tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // strobes into the link store memories
  typedef struct packed {
    logic hl_rd;
    logic hl_wr;
    logic link_rd;
    logic link_wr;
    logic tq_rd;
    logic tq_wr;
    logic tq_val;
  } store_cmd_t;

  // strobes into the level bitmap
  typedef struct packed {
    logic search;
    logic set;
    logic clr;
  } map_cmd_t;

endpackage

// ===== rtl/priority_bitmap_run_queue.sv =====
// top level of the bitmap priority run queue: sequencer and result register
//
//   channel  dir  word contents (low bit first)              accepted when
//   s_*      in   tdata: prio[6:0] task_id[12:7]; tuser: op   s_tvalid & s_tready
//   m_*      out  tdata: popped_task[5:0] running_count[12:6]; m_tvalid & m_tready
//                 tuser: found
//
// push: head/tail and queued-flag read, then write back
// pop of a queued task: group search, level search with head/tail
//   read, link read, head write back; an empty pop goes straight to its result
// every step is bound by the registered read of the memories
// after reset the queued-flag memory is swept entry by entry, s_tready low
// a finished word waits only if the previous result word is still not taken
`timescale 1ns / 1ps

module priority_bitmap_run_queue #(
  parameter int NUM_PRIO  = prq_pkg::NUM_PRIO_DEF,
  parameter int NUM_TASKS = prq_pkg::NUM_TASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [prq_pkg::S_TDATA_W-1:0]   s_tdata,  // prio[6:0], task_id[12:7], zero[15:13]
  input  logic                            s_tuser,  // op[0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [prq_pkg::M_TDATA_W-1:0]   m_tdata,  // popped_task[5:0], running_count[12:6]
  output logic                            m_tuser   // found[0]
);

  localparam int PW = $clog2(NUM_PRIO);
  localparam int TW = $clog2(NUM_TASKS);
  localparam int CW = $clog2(NUM_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_LVL,
    S_POP_HEAD,
    S_POP_LINK,
    S_EMPTY
  } state_t;

  state_t st;

  // input word fields
  logic [prq_pkg::PRIO_W-1:0] in_prio;
  logic [prq_pkg::TASK_W-1:0] in_task;
  logic                       in_take;

  // working registers of the current operation
  logic [PW-1:0] cur_prio;
  logic [PW-1:0] cur_level;
  logic [TW-1:0] cur_task;
  logic [TW-1:0] cur_head;
  logic          push_ok;
  logic          last_one;
  logic [CW-1:0] count;
  logic [CW-1:0] count_inc;
  logic          push_do;

  // result register
  logic [prq_pkg::TASK_W-1:0]  out_task;
  logic                        out_found;
  logic [prq_pkg::COUNT_W-1:0] out_count;
  logic                        out_free;
  logic                        out_load;

  // level map hookup
  prq_pkg::map_cmd_t mcmd;
  logic [PW-1:0]     lm_level;
  logic              lm_hit;
  logic              lm_any;
  logic [PW-1:0]     lm_first;

  // link store hookup
  prq_pkg::store_cmd_t scmd;
  logic [PW-1:0] hl_addr;
  logic [TW-1:0] hl_wr_head;
  logic [TW-1:0] hl_wr_tail;
  logic [TW-1:0] hl_head;
  logic [TW-1:0] hl_tail;
  logic [TW-1:0] link_addr;
  logic [TW-1:0] link_rdata;
  logic [TW-1:0] tq_addr;
  logic          tq_rdata;
  logic          init_busy;

  assign in_prio = s_tdata[prq_pkg::PRIO_W-1:0];
  assign in_task = s_tdata[prq_pkg::PRIO_W +: prq_pkg::TASK_W];

  assign s_tready  = (st == S_IDLE) && !init_busy;
  assign in_take   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign count_inc = count + 1'b1;

  // a result word is loaded in the last state of every operation
  assign out_load = out_free && ((st == S_PUSH) || (st == S_POP_LINK) || (st == S_EMPTY));

  // a push only lands for an in-range task that is not queued yet
  assign push_do = push_ok && !tq_rdata;

  assign m_tdata = prq_pkg::M_TDATA_W'({out_count, out_task});
  assign m_tuser = out_found;

  prq_level_map #(
    .NUM_PRIO (NUM_PRIO)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mcmd),
    .level (lm_level),
    .hit   (lm_hit),
    .any   (lm_any),
    .first (lm_first)
  );

  prq_link_store #(
    .NUM_PRIO  (NUM_PRIO),
    .NUM_TASKS (NUM_TASKS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (scmd),
    .hl_addr    (hl_addr),
    .hl_wr_head (hl_wr_head),
    .hl_wr_tail (hl_wr_tail),
    .hl_head    (hl_head),
    .hl_tail    (hl_tail),
    .link_addr  (link_addr),
    .link_wdata (cur_task),
    .link_rdata (link_rdata),
    .tq_addr    (tq_addr),
    .tq_rdata   (tq_rdata),
    .init_busy  (init_busy)
  );

  // memory and bitmap strobes per state
  always_comb begin
    scmd       = '0;
    mcmd       = '0;
    hl_addr    = cur_level;
    hl_wr_head = hl_head;
    hl_wr_tail = hl_tail;
    link_addr  = hl_head;
    tq_addr    = cur_task;
    lm_level   = cur_level;
    unique case (st)
      S_IDLE: begin
        hl_addr = PW'(in_prio);
        tq_addr = TW'(in_task);
        if (in_take) begin
          if (s_tuser == prq_pkg::OP_PUSH) begin
            scmd.hl_rd = 1'b1;
            scmd.tq_rd = 1'b1;
          end else begin
            mcmd.search = lm_any;
          end
        end
      end
      S_PUSH: begin
        hl_addr    = cur_prio;
        lm_level   = cur_prio;
        link_addr  = hl_tail;
        hl_wr_tail = cur_task;
        // empty level: new task is head and tail
        if (!lm_hit) hl_wr_head = cur_task;
        if (out_free && push_do) begin
          scmd.hl_wr   = 1'b1;
          scmd.tq_wr   = 1'b1;
          scmd.tq_val  = 1'b1;
          scmd.link_wr = lm_hit;
          mcmd.set     = !lm_hit;
        end
      end
      S_POP_LVL: begin
        hl_addr    = lm_first;
        scmd.hl_rd = 1'b1;
      end
      S_POP_HEAD: begin
        link_addr    = hl_head;
        tq_addr      = hl_head;
        scmd.link_rd = 1'b1;
        scmd.tq_wr   = 1'b1;
        // level drains when its head is also its tail
        mcmd.clr     = (hl_head == hl_tail);
      end
      S_POP_LINK: begin
        hl_wr_head = link_rdata;
        scmd.hl_wr = out_free && !last_one;
      end
      S_EMPTY: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_take) begin
            cur_prio <= PW'(in_prio);
            cur_task <= TW'(in_task);
            push_ok  <= (int'(in_prio) < NUM_PRIO) && (int'(in_task) < NUM_TASKS);
            if (s_tuser == prq_pkg::OP_PUSH) begin
              st <= S_PUSH;
            end else if (lm_any) begin
              st <= S_POP_LVL;
            end else begin
              st <= S_EMPTY;
            end
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_task  <= '0;
            out_found <= 1'b0;
            if (push_do) begin
              count     <= count_inc;
              out_count <= prq_pkg::COUNT_W'(count_inc);
            end else begin
              out_count <= prq_pkg::COUNT_W'(count);
            end
            st <= S_IDLE;
          end
        end
        S_POP_LVL: begin
          cur_level <= lm_first;
          st        <= S_POP_HEAD;
        end
        S_POP_HEAD: begin
          cur_head <= hl_head;
          last_one <= (hl_head == hl_tail);
          count    <= count - 1'b1;
          st       <= S_POP_LINK;
        end
        S_POP_LINK: begin
          if (out_free) begin
            out_task  <= prq_pkg::TASK_W'(cur_head);
            out_found <= 1'b1;
            out_count <= prq_pkg::COUNT_W'(count);
            st        <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_task  <= '0;
            out_found <= 1'b0;
            out_count <= prq_pkg::COUNT_W'(count);
            st        <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // some level is busy exactly when tasks are queued
  a_bitmap_vs_count: assert property (@(posedge clk) disable iff (rst)
    lm_any == (count != '0))
    else $error("level bitmap disagrees with queued count");

  // the queued count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == CW'($past(count) + 1'b1) || count == CW'($past(count) - 1'b1)))
    else $error("queued count jumped");

  // the level chosen by a pop is busy when its head is taken
  a_pop_level_busy: assert property (@(posedge clk) disable iff (rst)
    (st == S_POP_HEAD) |-> lm_hit)
    else $error("pop picked an empty level");

  // a new word is never taken while the sweep after reset runs
  a_no_take_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !s_tready)
    else $error("input taken during queued-flag sweep");

endmodule

// ===== rtl/prq_level_map.sv =====
// level bitmap with a two-step grouped search for the most urgent busy level
`timescale 1ns / 1ps

module prq_level_map #(
  parameter int NUM_PRIO = prq_pkg::NUM_PRIO_DEF,
  localparam int PW = $clog2(NUM_PRIO)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  prq_pkg::map_cmd_t    cmd,
  input  logic [PW-1:0]        level,
  output logic                 hit,
  output logic                 any,
  output logic [PW-1:0]        first
);

  localparam int G   = prq_pkg::GROUP_W;
  localparam int GBW = prq_pkg::GROUP_BIT_W;
  localparam int NG  = (NUM_PRIO + G - 1) / G;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int NGP = 1 << GW;

  logic [NUM_PRIO-1:0] bitmap;
  logic [NGP*G-1:0]    padded;
  logic [G-1:0]        words [NGP];
  logic [NGP-1:0]      summary;
  logic [GW-1:0]       grp;
  logic [GW-1:0]       grp_next;
  logic [G-1:0]        word_sel;
  logic [GBW-1:0]      bit_next;
  logic [GW+GBW-1:0]   first_wide;

  assign padded = (NGP*G)'(bitmap);

  always_comb begin
    for (int g = 0; g < NGP; g++) begin
      words[g]   = padded[g*G +: G];
      summary[g] = |padded[g*G +: G];
    end
  end

  assign any = |summary;
  assign hit = bitmap[level];

  // lowest busy group, taken when a pop starts
  always_comb begin
    grp_next = '0;
    for (int g = NGP - 1; g >= 0; g--) begin
      if (summary[g]) grp_next = GW'(g);
    end
  end

  // lowest busy level inside the chosen group
  always_comb begin
    word_sel = words[grp];
    bit_next = '0;
    for (int j = G - 1; j >= 0; j--) begin
      if (word_sel[j]) bit_next = GBW'(j);
    end
  end

  assign first_wide = {grp, bit_next};
  assign first      = PW'(first_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap <= '0;
      grp    <= '0;
    end else begin
      if (cmd.search) grp <= grp_next;
      if (cmd.set) bitmap[level] <= 1'b1;
      if (cmd.clr) bitmap[level] <= 1'b0;
    end
  end

endmodule

// ===== rtl/prq_link_store.sv =====
// head/tail, successor link and queued-flag memories of the run queue
`timescale 1ns / 1ps

module prq_link_store #(
  parameter int NUM_PRIO  = prq_pkg::NUM_PRIO_DEF,
  parameter int NUM_TASKS = prq_pkg::NUM_TASKS_DEF,
  localparam int PW = $clog2(NUM_PRIO),
  localparam int TW = $clog2(NUM_TASKS)
) (
  input  logic                clk,
  input  logic                rst,
  input  prq_pkg::store_cmd_t cmd,
  input  logic [PW-1:0]       hl_addr,
  input  logic [TW-1:0]       hl_wr_head,
  input  logic [TW-1:0]       hl_wr_tail,
  output logic [TW-1:0]       hl_head,
  output logic [TW-1:0]       hl_tail,
  input  logic [TW-1:0]       link_addr,
  input  logic [TW-1:0]       link_wdata,
  output logic [TW-1:0]       link_rdata,
  input  logic [TW-1:0]       tq_addr,
  output logic                tq_rdata,
  output logic                init_busy
);

  logic [2*TW-1:0] hl_mem   [NUM_PRIO];
  logic [TW-1:0]   link_mem [NUM_TASKS];
  logic            tq_mem   [NUM_TASKS];
  logic [TW-1:0]   clr_idx;

  // head in the upper half, tail in the lower half
  always_ff @(posedge clk) begin
    if (cmd.hl_wr) hl_mem[hl_addr] <= {hl_wr_head, hl_wr_tail};
    if (cmd.hl_rd) {hl_head, hl_tail} <= hl_mem[hl_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.link_wr) link_mem[link_addr] <= link_wdata;
    if (cmd.link_rd) link_rdata <= link_mem[link_addr];
  end

  // queued flags are swept to zero after reset
  always_ff @(posedge clk) begin
    if (init_busy) begin
      tq_mem[clr_idx] <= 1'b0;
    end else if (cmd.tq_wr) begin
      tq_mem[tq_addr] <= cmd.tq_val;
    end
    if (cmd.tq_rd) tq_rdata <= tq_mem[tq_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      init_busy <= 1'b1;
    end else if (init_busy) begin
      if (clr_idx == TW'(NUM_TASKS - 1)) begin
        init_busy <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

endmodule

// ===== verif/priority_bitmap_run_queue_tb.sv =====
// self-checking testbench for the bitmap priority run queue: push/pop streams against a predictor
`timescale 1ns / 1ps

module priority_bitmap_run_queue_tb;

  localparam int NUM_PRIO    = prq_pkg::NUM_PRIO_DEF;
  localparam int NUM_TASKS   = prq_pkg::NUM_TASKS_DEF;
  localparam int PRIO_W      = prq_pkg::PRIO_W;
  localparam int TASK_W      = prq_pkg::TASK_W;
  localparam int COUNT_W     = prq_pkg::COUNT_W;
  localparam int PAD_W       = prq_pkg::S_TDATA_W - TASK_W - PRIO_W;
  localparam int RANDOM_OPS  = 1850;
  // worst case is far below this: ~2k words, gaps, stalls, two long holds
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 600;

  // one expected result word
  typedef struct packed {
    logic [TASK_W-1:0]  task_out;
    logic               found;
    logic [COUNT_W-1:0] count;
  } rq_result_t;

  // shadow of the run queue plus the list of result words still due
  class ready_queue_tracker;
    bit              level_busy  [NUM_PRIO];
    bit [TASK_W-1:0] level_first [NUM_PRIO];
    bit [TASK_W-1:0] level_last  [NUM_PRIO];
    bit [TASK_W-1:0] follower    [NUM_TASKS];
    bit              waiting     [NUM_TASKS];
    int unsigned     queued;
    rq_result_t      due_words[$];
    int              mismatches;
    int              words_checked;
    int              pushes;
    int              dup_pushes;
    int              hits;
    int              empty_pops;
    int unsigned     peak;

    function new();
      queued        = 0;
      mismatches    = 0;
      words_checked = 0;
      pushes        = 0;
      dup_pushes    = 0;
      hits          = 0;
      empty_pops    = 0;
      peak          = 0;
      foreach (level_busy[i]) level_busy[i] = 1'b0;
      foreach (waiting[i]) waiting[i] = 1'b0;
    endfunction

    function bit is_free(logic [TASK_W-1:0] tid);
      return !waiting[tid];
    endfunction

    function int outstanding();
      return due_words.size();
    endfunction

    // apply one accepted input word to the shadow and queue its result
    function void apply_op(logic op, logic [PRIO_W-1:0] prio, logic [TASK_W-1:0] tid);
      rq_result_t      r;
      int              lvl;
      bit [TASK_W-1:0] h;
      r   = '0;
      lvl = -1;
      if (op == prq_pkg::OP_PUSH) begin
        pushes++;
        // field widths match NUM_PRIO and NUM_TASKS, so only a queued task is ignored
        if (waiting[tid]) begin
          dup_pushes++;
        end else begin
          if (level_busy[prio]) begin
            follower[level_last[prio]] = tid;
          end else begin
            level_first[prio] = tid;
            level_busy[prio]  = 1'b1;
          end
          level_last[prio] = tid;
          waiting[tid]     = 1'b1;
          queued++;
        end
      end else begin
        for (int i = 0; i < NUM_PRIO && lvl < 0; i++) begin
          if (level_busy[i]) lvl = i;
        end
        if (lvl < 0) begin
          empty_pops++;
        end else begin
          hits++;
          h = level_first[lvl];
          if (h == level_last[lvl]) level_busy[lvl] = 1'b0;
          else level_first[lvl] = follower[h];
          waiting[h] = 1'b0;
          if (queued > 0) queued--;
          r.task_out = h;
          r.found    = 1'b1;
        end
      end
      r.count = COUNT_W'(queued);
      if (queued > peak) peak = queued;
      due_words.push_back(r);
    endfunction

    // compare one accepted output word with the oldest expected result
    function void compare_word(logic [prq_pkg::M_TDATA_W-1:0] tdata, logic tuser);
      rq_result_t         want;
      logic [TASK_W-1:0]  got_task;
      logic [COUNT_W-1:0] got_count;
      got_task  = tdata[TASK_W-1:0];
      got_count = tdata[TASK_W+COUNT_W-1:TASK_W];
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: task %0d found %0b count %0d",
                   got_task, tuser, got_count);
        return;
      end
      want = due_words.pop_front();
      words_checked++;
      if (got_task !== want.task_out || tuser !== want.found || got_count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d: expected task %0d found %0b count %0d, got task %0d found %0b count %0d",
                   words_checked, want.task_out, want.found, want.count,
                   got_task, tuser, got_count);
      end
    endfunction
  endclass

  // clock, reset and dut ports; the driven ones are known from time zero
  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [prq_pkg::S_TDATA_W-1:0]   s_tdata  = '0;  // prio[6:0], task_id[12:7], zero[15:13]
  logic                            s_tuser  = 1'b0; // op[0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [prq_pkg::M_TDATA_W-1:0]   m_tdata;  // popped_task[5:0], running_count[12:6]
  logic                            m_tuser;  // found[0]

  ready_queue_tracker board;
  int                 results_seen = 0;
  int                 cycles       = 0;
  int                 long_holds   = 0;
  int                 burst_left   = 1;

  always #5 clk = ~clk;

  priority_bitmap_run_queue #(
    .NUM_PRIO  (NUM_PRIO),
    .NUM_TASKS (NUM_TASKS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words still due", cycles,
               board.outstanding());
      $display("[priority_bitmap_run_queue] ERROR");
      $finish;
    end
  end

  // result monitor: every accepted output word goes to the checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.compare_word(m_tdata, m_tuser);
      results_seen <= results_seen + 1;
    end
  end

  // receiver: ready pattern changes every so often, plus two long holds
  initial begin : rx_pattern
    int hold_left;
    int mode_left;
    int ready_pct;
    hold_left = 0;
    mode_left = 0;
    ready_pct = 100;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && long_holds < 2 && results_seen >= 300 + 900 * long_holds) begin
        // hold off long enough for the result register to fill and s_tready to drop
        hold_left = LONG_HOLD;
        long_holds++;
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 50;
          default: ready_pct = 12;
        endcase
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // offer one word from the falling edge until the rising edge that accepts it
  task automatic offer_word(input logic op, input logic [PRIO_W-1:0] prio,
                            input logic [TASK_W-1:0] tid);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{PAD_W{1'b0}}, tid, prio};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.apply_op(op, prio, tid);
  endtask

  task automatic hold_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // sender bursts: after each word count down the burst, then maybe a gap
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      hold_sender(gap);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_paced(input logic op, input logic [PRIO_W-1:0] prio,
                            input logic [TASK_W-1:0] tid);
    offer_word(op, prio, tid);
    pace();
  endtask

  // stop offering until every expected result word has come back
  task automatic drain_results();
    hold_sender(1);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // mostly a task that is not queued yet, so pushes really land
  function automatic logic [TASK_W-1:0] pick_task(input bit prefer_free);
    logic [TASK_W-1:0] start;
    start = $urandom_range(0, NUM_TASKS - 1);
    if (prefer_free) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        if (board.is_free(TASK_W'(start + k))) return TASK_W'(start + k);
      end
    end
    return start;
  endfunction

  // levels cluster near the top so FIFOs get deep, extremes show up often
  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return PRIO_W'($urandom_range(0, 7));
    if (r == 6) return '0;
    if (r == 7) return PRIO_W'(NUM_PRIO - 1);
    return PRIO_W'($urandom_range(0, NUM_PRIO - 1));
  endfunction

  initial begin : stimulus
    int               sent;
    int               phase_len;
    int               push_pct;
    logic             op;
    logic [TASK_W-1:0] tid;
    board = new();
    sent  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pop, field extremes, duplicates, fifo order within a level
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);   // pop of an empty queue
    send_paced(prq_pkg::OP_PUSH, 7'd127, 6'd63);  // lowest urgency, top task id
    send_paced(prq_pkg::OP_PUSH, 7'd0,   6'd0);   // most urgent, task zero
    send_paced(prq_pkg::OP_PUSH, 7'd0,   6'd0);   // duplicate, same level
    send_paced(prq_pkg::OP_PUSH, 7'd5,   6'd63);  // duplicate, other level
    send_paced(prq_pkg::OP_PUSH, 7'd0,   6'd42);
    send_paced(prq_pkg::OP_PUSH, 7'd85,  6'd21);
    send_paced(prq_pkg::OP_PUSH, 7'd0,   6'd5);
    send_paced(prq_pkg::OP_POP,  7'd127, 6'd63);  // ignored fields set on a pop
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);
    send_paced(prq_pkg::OP_PUSH, 7'd0,   6'd0);   // reuse a task just popped
    send_paced(prq_pkg::OP_POP,  7'd42,  6'd21);
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);   // level 0 now empty, falls to 85
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);   // empty again
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);
    send_paced(prq_pkg::OP_PUSH, 7'd126, 6'd62);
    send_paced(prq_pkg::OP_PUSH, 7'd1,   6'd1);
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);
    send_paced(prq_pkg::OP_POP,  7'd0,   6'd0);
    drain_results();

    // random phases: fill-heavy, balanced and drain-heavy mixes
    while (sent < RANDOM_OPS) begin
      case ($urandom_range(0, 2))
        0: push_pct = 90;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      phase_len = $urandom_range(30, 150);
      repeat (phase_len) begin
        op  = ($urandom_range(0, 99) < push_pct) ? prq_pkg::OP_PUSH : prq_pkg::OP_POP;
        tid = pick_task((op == prq_pkg::OP_PUSH) && ($urandom_range(0, 99) < 85));
        send_paced(op, pick_prio(), tid);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    drain_results();
    repeat (16) @(posedge clk);

    $display("covered %0d pushes (%0d ignored as already queued), %0d pops with a task, %0d empty pops",
             board.pushes, board.dup_pushes, board.hits, board.empty_pops);
    $display("peak occupancy %0d tasks, %0d result words checked, %0d long output holds, %0d mismatches",
             board.peak, board.words_checked, long_holds, board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("[priority_bitmap_run_queue] OK");
    end else begin
      $display("[priority_bitmap_run_queue] ERROR");
    end
    $finish;
  end

endmodule
